// ===== src/cjq_pkg.sv =====
// ----------------------------------------------------------------------------
// cjq_pkg
// Shared types and constants of the coalescing job queue: request kinds,
// status codes, configuration indexes, queue entry and result layouts, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cjq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TYPE_COUNT_MAX  = 16;

    localparam int KIND_W   = 4;
    localparam int TYPE_W   = 4;
    localparam int HANDLE_W = 16;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int TCNT_W   = 5;
    localparam int MASK_W   = 16;
    localparam int LIMIT_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] K_SCHEDULE   = 4'd0;
    localparam logic [KIND_W-1:0] K_PRIORITIZE = 4'd1;
    localparam logic [KIND_W-1:0] K_CANCEL     = 4'd2;
    localparam logic [KIND_W-1:0] K_CANCEL_ALL = 4'd3;
    localparam logic [KIND_W-1:0] K_START_NEXT = 4'd4;
    localparam logic [KIND_W-1:0] K_COMPLETE   = 4'd5;
    localparam logic [KIND_W-1:0] K_QUERY_FIN  = 4'd6;
    localparam logic [KIND_W-1:0] K_SYNC       = 4'd7;
    localparam logic [KIND_W-1:0] K_STALL      = 4'd8;
    localparam logic [KIND_W-1:0] K_TICK       = 4'd9;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADTYPE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OW_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIM  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TYPE_W-1:0]   jtype;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Result layout, listed from the top bit down.
    typedef struct packed {
        logic                stalled;
        logic [ID_W-1:0]     wait_target;
        logic                finished;
        logic [HANDLE_W-1:0] freed_handle;
        logic                freed_valid;
        logic [HANDLE_W-1:0] result_handle;
        logic [TYPE_W-1:0]   result_type;
        logic [ID_W-1:0]     result_id;
        logic [STATUS_W-1:0] status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_NEXT,
        OP_BADTYPE,
        OP_OVERWRITE,
        OP_FULL,
        OP_APPEND,
        OP_NOTFOUND,
        OP_HOLD,
        OP_READ_M1,
        OP_WRITE_DEC,
        OP_PLACE,
        OP_CANCEL_HIT,
        OP_READ_P1,
        OP_WRITE_INC,
        OP_POP_END,
        OP_CLEAR_ALL,
        OP_EMPTY,
        OP_START,
        OP_COMPLETE,
        OP_FIN_NONE,
        OP_SYNC_RUN,
        OP_SYNC_POS,
        OP_SYNC_MISS,
        OP_STALL,
        OP_TICK,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              bad_type;
        logic              ow_bit;
        logic              empty;
        logic              full;
        logic              match;
        logic              idx_last;
        logic              idx_gt_pp;
        logic              run_match;
        logic              out_valid;
    } dp_stat_t;

endpackage

// ===== src/cjq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cjq_ctrl
// Sequencer of the job queue: decodes each request and walks the datapath
// through searches, entry moves and the result hand-off.
// ----------------------------------------------------------------------------
module cjq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  cjq_pkg::dp_stat_t stat,
    output cjq_pkg::dp_op_t   op
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_SRD      = 10'b00_0000_0100,
        S_SCMP     = 10'b00_0000_1000,
        S_PRI_RD   = 10'b00_0001_0000,
        S_PRI_WR   = 10'b00_0010_0000,
        S_REM_CHK  = 10'b00_0100_0000,
        S_REM_WR   = 10'b00_1000_0000,
        S_START    = 10'b01_0000_0000,
        S_FIN      = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Outcome of a request whose search finds nothing, or that needs no search.
    function automatic cjq_pkg::dp_op_t miss_op(input logic [cjq_pkg::KIND_W-1:0] kind,
                                                input logic full);
        cjq_pkg::dp_op_t r;
        r = cjq_pkg::OP_NONE;
        case (kind)
            cjq_pkg::K_SCHEDULE:  r = full ? cjq_pkg::OP_FULL : cjq_pkg::OP_APPEND;
            cjq_pkg::K_QUERY_FIN: r = cjq_pkg::OP_FIN_NONE;
            cjq_pkg::K_SYNC:      r = cjq_pkg::OP_SYNC_MISS;
            default:              r = cjq_pkg::OP_NOTFOUND;
        endcase
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = cjq_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = cjq_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FIN;
                case (stat.kind)
                    cjq_pkg::K_SCHEDULE:
                    begin
                        if (stat.bad_type)
                            op = cjq_pkg::OP_BADTYPE;
                        else if (stat.ow_bit && !stat.empty)
                            state_next = S_SRD;
                        else
                            op = miss_op(stat.kind, stat.full);
                    end
                    cjq_pkg::K_PRIORITIZE, cjq_pkg::K_CANCEL, cjq_pkg::K_QUERY_FIN:
                    begin
                        if (stat.empty)
                            op = miss_op(stat.kind, stat.full);
                        else
                            state_next = S_SRD;
                    end
                    cjq_pkg::K_SYNC:
                    begin
                        if (stat.run_match)
                            op = cjq_pkg::OP_SYNC_RUN;
                        else if (stat.empty)
                            op = cjq_pkg::OP_SYNC_MISS;
                        else
                            state_next = S_SRD;
                    end
                    cjq_pkg::K_CANCEL_ALL: op = cjq_pkg::OP_CLEAR_ALL;
                    cjq_pkg::K_START_NEXT:
                    begin
                        if (stat.empty)
                            op = cjq_pkg::OP_EMPTY;
                        else
                        begin
                            op         = cjq_pkg::OP_READ;
                            state_next = S_START;
                        end
                    end
                    cjq_pkg::K_COMPLETE: op = cjq_pkg::OP_COMPLETE;
                    cjq_pkg::K_STALL:    op = cjq_pkg::OP_STALL;
                    cjq_pkg::K_TICK:     op = cjq_pkg::OP_TICK;
                    default:             op = cjq_pkg::OP_NONE;
                endcase
            end
            S_SRD:
            begin
                op         = cjq_pkg::OP_READ;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                state_next = S_FIN;
                if (stat.match)
                begin
                    case (stat.kind)
                        cjq_pkg::K_SCHEDULE: op = cjq_pkg::OP_OVERWRITE;
                        cjq_pkg::K_PRIORITIZE:
                        begin
                            if (stat.idx_gt_pp)
                            begin
                                op         = cjq_pkg::OP_HOLD;
                                state_next = S_PRI_RD;
                            end
                        end
                        cjq_pkg::K_CANCEL:
                        begin
                            op         = cjq_pkg::OP_CANCEL_HIT;
                            state_next = S_REM_CHK;
                        end
                        cjq_pkg::K_SYNC: op = cjq_pkg::OP_SYNC_POS;
                        default:         op = cjq_pkg::OP_NONE;
                    endcase
                end
                else if (stat.idx_last)
                    op = miss_op(stat.kind, stat.full);
                else
                begin
                    op         = cjq_pkg::OP_NEXT;
                    state_next = S_SRD;
                end
            end
            S_PRI_RD:
            begin
                if (stat.idx_gt_pp)
                begin
                    op         = cjq_pkg::OP_READ_M1;
                    state_next = S_PRI_WR;
                end
                else
                begin
                    op         = cjq_pkg::OP_PLACE;
                    state_next = S_FIN;
                end
            end
            S_PRI_WR:
            begin
                op         = cjq_pkg::OP_WRITE_DEC;
                state_next = S_PRI_RD;
            end
            S_REM_CHK:
            begin
                if (stat.idx_last)
                begin
                    op         = cjq_pkg::OP_POP_END;
                    state_next = S_FIN;
                end
                else
                begin
                    op         = cjq_pkg::OP_READ_P1;
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                op         = cjq_pkg::OP_WRITE_INC;
                state_next = S_REM_CHK;
            end
            S_START:
            begin
                op         = cjq_pkg::OP_START;
                state_next = S_REM_CHK;
            end
            S_FIN:
            begin
                if (!stat.out_valid || m_tready)
                begin
                    op         = cjq_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/cjq_dp.sv =====
// ----------------------------------------------------------------------------
// cjq_dp
// Datapath of the job queue: entry memory, queue counters, worker state,
// configuration registers and the result and output registers.
// ----------------------------------------------------------------------------
module cjq_dp
#(
    parameter int QUEUE_DEPTH = cjq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cjq_pkg::dp_op_t                   op,
    output cjq_pkg::dp_stat_t                 stat,
    input  logic [cjq_pkg::KIND_W-1:0]        in_kind,
    input  logic [cjq_pkg::TYPE_W-1:0]        in_type,
    input  logic [cjq_pkg::HANDLE_W-1:0]      in_handle,
    input  logic [cjq_pkg::ID_W-1:0]          in_id,
    input  logic                              cfg_we,
    input  logic [cjq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cjq_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              m_tready,
    output logic                              out_valid,
    output cjq_pkg::result_t                  out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cjq_pkg::entry_t mem [QUEUE_DEPTH];
    cjq_pkg::entry_t rd_data_reg, hold_reg, wr_data;
    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;

    logic [cjq_pkg::KIND_W-1:0]   kind_reg;
    logic [cjq_pkg::TYPE_W-1:0]   type_reg;
    logic [cjq_pkg::HANDLE_W-1:0] handle_reg;
    logic [cjq_pkg::ID_W-1:0]     id_reg;

    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next, pp_reg, pp_next;
    logic [cjq_pkg::ID_W-1:0] started_reg, started_next, completed_reg, completed_next;
    logic [cjq_pkg::ID_W-1:0] run_id_reg, run_id_next;
    logic                     running_reg, running_next;
    logic [cjq_pkg::LIMIT_W-1:0] elapsed_reg, elapsed_next;

    logic [cjq_pkg::TCNT_W-1:0]  type_count_reg;
    logic [cjq_pkg::MASK_W-1:0]  ow_mask_reg;
    logic [cjq_pkg::LIMIT_W-1:0] stall_limit_reg;

    cjq_pkg::result_t res_reg, res_next;
    logic             out_valid_reg;

    logic [CW-1:0] idx_w;
    assign idx_w = CW'(idx_reg);

    assign stat.kind      = kind_reg;
    assign stat.bad_type  = ({1'b0, type_reg} >= type_count_reg)
                          || ({3'b000, type_reg} >= 7'(cjq_pkg::TYPE_COUNT_MAX));
    assign stat.ow_bit    = ow_mask_reg[type_reg];
    assign stat.empty     = (cnt_reg == '0);
    assign stat.full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign stat.match     = (kind_reg == cjq_pkg::K_SCHEDULE) ? (rd_data_reg.jtype == type_reg)
                                                               : (rd_data_reg.id == id_reg);
    assign stat.idx_last  = ((idx_w + CW'(1)) >= cnt_reg);
    assign stat.idx_gt_pp = (idx_w > pp_reg);
    assign stat.run_match = running_reg && (run_id_reg == id_reg);
    assign stat.out_valid = out_valid_reg;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pp_next        = pp_reg;
        started_next   = started_reg;
        completed_next = completed_reg;
        run_id_next    = run_id_reg;
        running_next   = running_reg;
        elapsed_next   = elapsed_reg;
        res_next       = res_reg;
        case (op)
            cjq_pkg::OP_LOAD:
            begin
                res_next = '0;
                idx_next = '0;
            end
            cjq_pkg::OP_READ: rd_en = 1'b1;
            cjq_pkg::OP_NEXT: idx_next = idx_reg + AW'(1);
            cjq_pkg::OP_BADTYPE: res_next.status = cjq_pkg::ST_BADTYPE;
            cjq_pkg::OP_OVERWRITE:
            begin
                wr_en                 = 1'b1;
                wr_data.handle        = handle_reg;
                res_next.freed_valid  = 1'b1;
                res_next.freed_handle = rd_data_reg.handle;
                res_next.result_id    = rd_data_reg.id;
            end
            cjq_pkg::OP_FULL: res_next.status = cjq_pkg::ST_FULL;
            cjq_pkg::OP_APPEND:
            begin
                wr_en              = 1'b1;
                wr_addr            = cnt_reg[AW-1:0];
                wr_data.id         = started_reg + cjq_pkg::ID_W'(cnt_reg);
                wr_data.jtype      = type_reg;
                wr_data.handle     = handle_reg;
                res_next.result_id = started_reg + cjq_pkg::ID_W'(cnt_reg);
                cnt_next           = cnt_reg + CW'(1);
            end
            cjq_pkg::OP_NOTFOUND: res_next.status = cjq_pkg::ST_NOTFOUND;
            cjq_pkg::OP_HOLD: ;
            cjq_pkg::OP_READ_M1:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg - AW'(1);
            end
            cjq_pkg::OP_WRITE_DEC:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg - AW'(1);
            end
            cjq_pkg::OP_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = pp_reg[AW-1:0];
                wr_data = hold_reg;
                pp_next = pp_reg + CW'(1);
            end
            cjq_pkg::OP_CANCEL_HIT:
            begin
                res_next.freed_valid  = 1'b1;
                res_next.freed_handle = rd_data_reg.handle;
            end
            cjq_pkg::OP_READ_P1:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + AW'(1);
            end
            cjq_pkg::OP_WRITE_INC:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + AW'(1);
            end
            cjq_pkg::OP_POP_END: cnt_next = cnt_reg - CW'(1);
            cjq_pkg::OP_CLEAR_ALL: cnt_next = '0;
            cjq_pkg::OP_EMPTY: res_next.status = cjq_pkg::ST_EMPTY;
            cjq_pkg::OP_START:
            begin
                res_next.result_id     = rd_data_reg.id;
                res_next.result_type   = rd_data_reg.jtype;
                res_next.result_handle = rd_data_reg.handle;
                run_id_next            = rd_data_reg.id;
                running_next           = 1'b1;
                elapsed_next           = '0;
                started_next           = started_reg + 32'd1;
                if (pp_reg != '0)
                    pp_next = pp_reg - CW'(1);
            end
            cjq_pkg::OP_COMPLETE:
            begin
                if (running_reg)
                begin
                    completed_next = completed_reg + 32'd1;
                    running_next   = 1'b0;
                    run_id_next    = '0;
                    elapsed_next   = '0;
                end
            end
            cjq_pkg::OP_FIN_NONE: res_next.finished = !stat.run_match;
            cjq_pkg::OP_SYNC_RUN: res_next.wait_target = started_reg;
            cjq_pkg::OP_SYNC_POS:
                res_next.wait_target = started_reg + cjq_pkg::ID_W'(idx_reg) + 32'd1;
            cjq_pkg::OP_SYNC_MISS:
            begin
                res_next.status      = cjq_pkg::ST_NOTFOUND;
                res_next.wait_target = completed_reg;
            end
            cjq_pkg::OP_STALL:
            begin
                if (running_reg && (elapsed_reg > stall_limit_reg))
                begin
                    res_next.stalled   = 1'b1;
                    res_next.result_id = run_id_reg;
                end
            end
            cjq_pkg::OP_TICK:
            begin
                if (running_reg && (elapsed_reg != '1))
                    elapsed_next = elapsed_reg + 32'd1;
            end
            default: ;
        endcase
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (op == cjq_pkg::OP_LOAD)
        begin
            kind_reg   <= in_kind;
            type_reg   <= in_type;
            handle_reg <= in_handle;
            id_reg     <= in_id;
        end
        if (op == cjq_pkg::OP_HOLD)
            hold_reg <= rd_data_reg;
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (op == cjq_pkg::OP_EMIT)
            out_data <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            pp_reg          <= '0;
            started_reg     <= '0;
            completed_reg   <= '0;
            run_id_reg      <= '0;
            running_reg     <= 1'b0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
            type_count_reg  <= '0;
            ow_mask_reg     <= '0;
            stall_limit_reg <= '1;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pp_reg        <= pp_next;
            started_reg   <= started_next;
            completed_reg <= completed_next;
            run_id_reg    <= run_id_next;
            running_reg   <= running_next;
            elapsed_reg   <= elapsed_next;
            if (op == cjq_pkg::OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    cjq_pkg::CFG_TYPE_COUNT: type_count_reg  <= cfg_data[cjq_pkg::TCNT_W-1:0];
                    cjq_pkg::CFG_OW_MASK:    ow_mask_reg     <= cfg_data[cjq_pkg::MASK_W-1:0];
                    cjq_pkg::CFG_STALL_LIM:  stall_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTH
    // The pending count never exceeds the queue depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("pending count beyond queue depth");

    // The promotion position always addresses a real entry slot.
    a_pp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pp_reg < CW'(QUEUE_DEPTH))
        else $error("promotion position out of range");

    // An idle worker carries no id and no elapsed time.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (elapsed_reg == '0 && run_id_reg == '0))
        else $error("idle worker holds stale state");

    // An append always grows the queue by one entry.
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        op == cjq_pkg::OP_APPEND |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("append did not grow the queue");
`endif

endmodule

// ===== src/coalescing_job_queue_top.sv =====
// ----------------------------------------------------------------------------
// coalescing_job_queue_top
// Ordered pending-job queue with type coalescing, priority promotion and a
// single-worker stall timer.
// ----------------------------------------------------------------------------
// Each request on the slave stream yields exactly one result on the master
// stream. Requests are handled one at a time. Simple requests (cancel-all,
// start on an empty queue, complete, stall check, tick, and a schedule that
// needs no search) go from acceptance through the dispatch state straight to
// the result state, after which the controller returns to idle for the next
// request. Requests that look up a queued job walk the entry memory with a
// read state and a compare state per entry examined, because the single read
// port returns registered data. Prioritize, cancel and start move each
// shifted entry with a read state and a write state, so the worst case is a
// prioritize that finds its job in the last slot of a full queue. A finished
// result sits in an output register while the next request is already
// accepted and worked on; only the hand-off of the following result waits
// for the downstream side. The entry memory has no reset; an entry is only
// ever read after it has been written.
// ----------------------------------------------------------------------------
module coalescing_job_queue_top
#(
    parameter int QUEUE_DEPTH = cjq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: job_type[3:0], data_handle[19:4], job_id[51:20],
    // zero padding[55:52].
    input  logic [55:0]                   s_tdata,
    // Fields from bit 0: kind[3:0].
    input  logic [3:0]                    s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: status[2:0], result_id[34:3], result_type[38:35],
    // result_handle[54:39], freed_valid[55], freed_handle[71:56],
    // finished[72], wait_target[104:73], stalled[105], zero padding[111:106].
    output logic [111:0]                  m_tdata,

    input  logic                          cfg_we,
    input  logic [cjq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cjq_pkg::CFG_W-1:0]     cfg_data
);

    cjq_pkg::dp_op_t   op;
    cjq_pkg::dp_stat_t stat;
    cjq_pkg::result_t  out_data;

    cjq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .op       (op)
    );

    cjq_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .in_kind   (s_tuser),
        .in_type   (s_tdata[3:0]),
        .in_handle (s_tdata[19:4]),
        .in_id     (s_tdata[51:20]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    // The result struct is declared top bit first, so it packs from status up.
    assign m_tdata = {{(112 - cjq_pkg::RESULT_W){1'b0}}, out_data};

endmodule

// ===== tb/sv/coalescing_job_queue_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_job_queue_top_test
// Self-checking testbench for the coalescing job queue.
// A predictor inside the bench keeps its own copy of the queue, counters and
// registers. It works out the result of every accepted request, and a checker
// compares each returned result with the oldest prediction, field by field.
// Directed requests come first. Randomized phases with different registers,
// and with idle or stalled stream sides, follow.
// ----------------------------------------------------------------------------
module coalescing_job_queue_top_test;

    localparam int QDEPTH       = cjq_pkg::QUEUE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 4 * QDEPTH + 20;  // worst request latency plus margin
    localparam int STUCK_LIMIT  = 5000;             // cycles with no handshake at all
    localparam logic [cjq_pkg::KIND_W-1:0] K_FIRST_UNUSED = 4'd10;
    localparam logic [cjq_pkg::KIND_W-1:0] K_LAST_UNUSED  = 4'd15;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [55:0]                   s_tdata;
    logic [3:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [111:0]                  m_tdata;
    logic                          cfg_we;
    logic [cjq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cjq_pkg::CFG_W-1:0]     cfg_data;

    // Percent of cycles in which the sender idles or the receiver stalls.
    int unsigned sender_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned mismatch_count;
    int unsigned stuck_cycles;

    // Predicted results, oldest first.
    cjq_pkg::result_t pending_results[$];

    // Predictor state: the queue, the worker and the registers.
    logic [cjq_pkg::ID_W-1:0]     q_id[QDEPTH];
    logic [cjq_pkg::TYPE_W-1:0]   q_type[QDEPTH];
    logic [cjq_pkg::HANDLE_W-1:0] q_handle[QDEPTH];
    int                           q_len;
    int                           promo_pos;
    logic [cjq_pkg::ID_W-1:0]     n_started;
    logic [cjq_pkg::ID_W-1:0]     n_completed;
    logic [cjq_pkg::ID_W-1:0]     run_id;
    logic                         run_active;
    logic [cjq_pkg::ID_W-1:0]     run_ticks;
    logic [cjq_pkg::TCNT_W-1:0]   reg_types;
    logic [cjq_pkg::MASK_W-1:0]   reg_ow_mask;
    logic [cjq_pkg::LIMIT_W-1:0]  reg_stall_lim;

    coalescing_job_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Position of a pending job with the given id, or q_len when it is absent.
    function automatic int find_job(logic [cjq_pkg::ID_W-1:0] id);
        int i;
        for (i = 0; i < q_len; i++)
            if (q_id[i] == id)
                return i;
        return q_len;
    endfunction

    function automatic void drop_entry(int pos);
        int i;
        for (i = pos; i + 1 < q_len; i++)
        begin
            q_id[i]     = q_id[i + 1];
            q_type[i]   = q_type[i + 1];
            q_handle[i] = q_handle[i + 1];
        end
        q_len--;
    endfunction

    // Applies one request to the predictor state and returns its result.
    function automatic cjq_pkg::result_t apply_request(
        logic [cjq_pkg::KIND_W-1:0]   kind,
        logic [cjq_pkg::TYPE_W-1:0]   jtype,
        logic [cjq_pkg::HANDLE_W-1:0] handle,
        logic [cjq_pkg::ID_W-1:0]     jid);
        cjq_pkg::result_t             r;
        int                           i;
        int                           pos;
        logic [cjq_pkg::ID_W-1:0]     sid;
        logic [cjq_pkg::TYPE_W-1:0]   sty;
        logic [cjq_pkg::HANDLE_W-1:0] sh;
        r = '0;
        case (kind)
            cjq_pkg::K_SCHEDULE:
            begin
                if (int'(jtype) >= int'(reg_types) || int'(jtype) >= cjq_pkg::TYPE_COUNT_MAX)
                    r.status = cjq_pkg::ST_BADTYPE;
                else
                begin
                    pos = -1;
                    if (reg_ow_mask[jtype])
                        for (i = 0; i < q_len; i++)
                            if (pos < 0 && q_type[i] == jtype)
                                pos = i;
                    if (pos >= 0)
                    begin
                        // Coalesce into the queued job of the same type.
                        r.freed_valid  = 1'b1;
                        r.freed_handle = q_handle[pos];
                        q_handle[pos]  = handle;
                        r.result_id    = q_id[pos];
                    end
                    else if (q_len >= QDEPTH)
                        r.status = cjq_pkg::ST_FULL;
                    else
                    begin
                        q_id[q_len]     = n_started + q_len;
                        q_type[q_len]   = jtype;
                        q_handle[q_len] = handle;
                        r.result_id     = q_id[q_len];
                        q_len++;
                    end
                end
            end
            cjq_pkg::K_PRIORITIZE:
            begin
                pos = find_job(jid);
                if (pos >= q_len)
                    r.status = cjq_pkg::ST_NOTFOUND;
                else if (pos > promo_pos)
                begin
                    sid = q_id[pos];
                    sty = q_type[pos];
                    sh  = q_handle[pos];
                    for (i = pos; i > promo_pos; i--)
                    begin
                        q_id[i]     = q_id[i - 1];
                        q_type[i]   = q_type[i - 1];
                        q_handle[i] = q_handle[i - 1];
                    end
                    q_id[promo_pos]     = sid;
                    q_type[promo_pos]   = sty;
                    q_handle[promo_pos] = sh;
                    promo_pos++;
                end
            end
            cjq_pkg::K_CANCEL:
            begin
                pos = find_job(jid);
                if (pos >= q_len)
                    r.status = cjq_pkg::ST_NOTFOUND;
                else
                begin
                    r.freed_valid  = 1'b1;
                    r.freed_handle = q_handle[pos];
                    drop_entry(pos);
                end
            end
            cjq_pkg::K_CANCEL_ALL:
                q_len = 0;
            cjq_pkg::K_START_NEXT:
            begin
                if (q_len == 0)
                    r.status = cjq_pkg::ST_EMPTY;
                else
                begin
                    r.result_id     = q_id[0];
                    r.result_type   = q_type[0];
                    r.result_handle = q_handle[0];
                    run_id     = q_id[0];
                    run_active = 1'b1;
                    run_ticks  = '0;
                    drop_entry(0);
                    n_started++;
                    if (promo_pos > 0)
                        promo_pos--;
                end
            end
            cjq_pkg::K_COMPLETE:
            begin
                if (run_active)
                begin
                    n_completed++;
                    run_active = 1'b0;
                    run_id     = '0;
                    run_ticks  = '0;
                end
            end
            cjq_pkg::K_QUERY_FIN:
                r.finished = (find_job(jid) >= q_len) && !(run_active && run_id == jid);
            cjq_pkg::K_SYNC:
            begin
                if (run_active && run_id == jid)
                    r.wait_target = n_started;
                else
                begin
                    pos = find_job(jid);
                    if (pos >= q_len)
                    begin
                        r.status      = cjq_pkg::ST_NOTFOUND;
                        r.wait_target = n_completed;
                    end
                    else
                        r.wait_target = n_started + pos + 1;
                end
            end
            cjq_pkg::K_STALL:
            begin
                if (run_active && run_ticks > reg_stall_lim)
                begin
                    r.stalled   = 1'b1;
                    r.result_id = run_id;
                end
            end
            cjq_pkg::K_TICK:
            begin
                if (run_active && run_ticks != '1)
                    run_ticks++;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Sends one request, idling first as the current phase asks.
    task automatic send_request(logic [cjq_pkg::KIND_W-1:0] kind,
                                logic [cjq_pkg::TYPE_W-1:0] jtype,
                                logic [cjq_pkg::HANDLE_W-1:0] handle,
                                logic [cjq_pkg::ID_W-1:0] jid);
        cjq_pkg::result_t predicted;
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, jid, handle, jtype};
        s_tuser  = kind;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(kind, jtype, handle, jid);
        pending_results.insert(pending_results.size(), predicted);
    endtask

    // Stops sending and waits until every predicted result has come back.
    // The extra cycles let the block settle before a register write.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [cjq_pkg::CFG_IDX_W-1:0] idx,
                             logic [cjq_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            cjq_pkg::CFG_TYPE_COUNT: reg_types     = value[cjq_pkg::TCNT_W-1:0];
            cjq_pkg::CFG_OW_MASK:    reg_ow_mask   = value[cjq_pkg::MASK_W-1:0];
            cjq_pkg::CFG_STALL_LIM:  reg_stall_lim = value[cjq_pkg::LIMIT_W-1:0];
            default:                 ;
        endcase
    endtask

    task automatic set_regs(logic [cjq_pkg::CFG_W-1:0] types,
                            logic [cjq_pkg::CFG_W-1:0] mask,
                            logic [cjq_pkg::CFG_W-1:0] lim);
        write_reg(cjq_pkg::CFG_TYPE_COUNT, types);
        write_reg(cjq_pkg::CFG_OW_MASK, mask);
        write_reg(cjq_pkg::CFG_STALL_LIM, lim);
    endtask

    // Mostly ids that the queue knows about, so that lookups hit; the rest are the
    // running id, ids just past the newest job, or random values over all id bits.
    function automatic logic [cjq_pkg::ID_W-1:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55 && q_len > 0)
            return q_id[$urandom_range(0, q_len - 1)];
        if (roll < 70)
            return run_id;
        if (roll < 85)
            return n_started + q_len + $urandom_range(0, 2);
        return $urandom;
    endfunction

    // One random request. sched_pct sets how often a schedule is sent, which
    // decides how full the queue tends to get.
    task automatic send_random(int unsigned sched_pct);
        int unsigned                roll;
        logic [cjq_pkg::KIND_W-1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < sched_pct)
            kind = cjq_pkg::K_SCHEDULE;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 14)      kind = cjq_pkg::K_PRIORITIZE;
            else if (roll < 26) kind = cjq_pkg::K_CANCEL;
            else if (roll < 28) kind = cjq_pkg::K_CANCEL_ALL;
            else if (roll < 46) kind = cjq_pkg::K_START_NEXT;
            else if (roll < 58) kind = cjq_pkg::K_COMPLETE;
            else if (roll < 68) kind = cjq_pkg::K_QUERY_FIN;
            else if (roll < 78) kind = cjq_pkg::K_SYNC;
            else if (roll < 85) kind = cjq_pkg::K_STALL;
            else if (roll < 97) kind = cjq_pkg::K_TICK;
            else
                kind = cjq_pkg::KIND_W'($urandom_range(K_FIRST_UNUSED, K_LAST_UNUSED));
        end
        send_request(kind, cjq_pkg::TYPE_W'($urandom), cjq_pkg::HANDLE_W'($urandom),
                     pick_id());
    endtask

    task automatic run_phase(int unsigned count, int unsigned idle_pct,
                             int unsigned stall_pct, int unsigned sched_pct);
        int unsigned n;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (n = 0; n < count; n++)
            send_random(sched_pct);
        wait_drained();
    endtask

    // Directed: invalid types, idle worker requests, coalescing, promotion,
    // cancel, queries, start, stall report and an unknown kind.
    task automatic test_directed();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        send_request(cjq_pkg::K_SCHEDULE, 4'd0, 16'h1234, '0);      // no types registered
        wait_drained();
        set_regs(32'd16, 32'h0000_8001, 32'd0);
        send_request(cjq_pkg::K_START_NEXT, '0, '0, '0);             // empty queue
        send_request(cjq_pkg::K_COMPLETE, '0, '0, '0);               // nothing running
        send_request(cjq_pkg::K_STALL, '0, '0, '0);
        send_request(cjq_pkg::K_TICK, '0, '0, '0);
        send_request(cjq_pkg::K_QUERY_FIN, '0, '0, 32'hFFFF_FFFF);
        send_request(cjq_pkg::K_SCHEDULE, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(cjq_pkg::K_SCHEDULE, 4'd3, 16'h0000, '0);
        send_request(cjq_pkg::K_SCHEDULE, 4'd0, 16'hA5A5, '0);
        send_request(cjq_pkg::K_SCHEDULE, 4'd15, 16'h5A5A, '0);     // coalesces into id 0
        send_request(cjq_pkg::K_SCHEDULE, 4'd7, 16'h0F0F, '0);
        send_request(cjq_pkg::K_PRIORITIZE, '0, '0, 32'd0);         // at the insert position
        send_request(cjq_pkg::K_PRIORITIZE, '0, '0, 32'd3);         // moves to the front
        send_request(cjq_pkg::K_PRIORITIZE, '0, '0, 32'hDEAD_BEEF); // unknown id
        send_request(cjq_pkg::K_SYNC, '0, '0, 32'd2);
        send_request(cjq_pkg::K_SYNC, '0, '0, 32'hDEAD_BEEF);
        send_request(cjq_pkg::K_CANCEL, '0, '0, 32'd1);
        send_request(cjq_pkg::K_CANCEL, '0, '0, 32'd1);             // already gone
        send_request(cjq_pkg::K_START_NEXT, '0, '0, '0);
        send_request(cjq_pkg::K_SYNC, '0, '0, 32'd3);                // the running job
        send_request(cjq_pkg::K_TICK, '0, '0, '0);
        send_request(cjq_pkg::K_STALL, '0, '0, '0);                  // limit 0 exceeded
        send_request(cjq_pkg::K_QUERY_FIN, '0, '0, 32'd3);
        send_request(K_LAST_UNUSED, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(cjq_pkg::K_CANCEL_ALL, '0, '0, '0);
        send_request(cjq_pkg::K_COMPLETE, '0, '0, '0);
        wait_drained();
    endtask

    // The sender stops mid-stream until every result is back, then resumes.
    task automatic test_drain_pause();
        int unsigned n;
        sender_idle_pct = 0;
        sink_stall_pct  = 30;
        for (n = 0; n < 40; n++)
            send_random(40);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (n = 0; n < 40; n++)
            send_random(40);
        wait_drained();
    endtask

    task automatic check_field(string name, logic [cjq_pkg::ID_W-1:0] want,
                               logic [cjq_pkg::ID_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        cjq_pkg::result_t want;
        cjq_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[cjq_pkg::RESULT_W-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("result_id", want.result_id, got.result_id);
                check_field("result_type", 32'(want.result_type), 32'(got.result_type));
                check_field("result_handle", 32'(want.result_handle),
                            32'(got.result_handle));
                check_field("freed_valid", 32'(want.freed_valid), 32'(got.freed_valid));
                check_field("freed_handle", 32'(want.freed_handle), 32'(got.freed_handle));
                check_field("finished", 32'(want.finished), 32'(got.finished));
                check_field("wait_target", want.wait_target, got.wait_target);
                check_field("stalled", 32'(want.stalled), 32'(got.stalled));
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
        m_tready = (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);

    // Watchdog: a long stretch with no handshake on any port means a hang.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        q_len = 0;
        promo_pos = 0;
        n_started = '0;
        n_completed = '0;
        run_id = '0;
        run_active = 1'b0;
        run_ticks = '0;
        reg_types = '0;
        reg_ow_mask = '0;
        reg_stall_lim = '1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();

        // No idling, all types valid, every type coalesced, stall never reported.
        set_regs(32'd16, 32'h0000_FFFF, 32'hFFFF_FFFF);
        run_phase(300, 0, 0, 45);
        // Sender idles, few types, no coalescing, the queue fills up.
        set_regs(32'd5, 32'h0000_0000, 32'd3);
        run_phase(300, 61, 0, 60);
        // Receiver stalls, random registers.
        set_regs($urandom_range(0, 16), $urandom_range(0, 16'hFFFF), $urandom_range(0, 6));
        run_phase(300, 0, 61, 40);
        // Both sides idle now and then.
        set_regs(32'd16, $urandom_range(0, 16'hFFFF), 32'd0);
        run_phase(300, 8, 8, 35);
        test_drain_pause();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/cjq_pkg.sv
src/cjq_ctrl.sv
src/cjq_dp.sv
src/coalescing_job_queue_top.sv
tb/sv/coalescing_job_queue_top_test.sv
